// ===== rtl/itdt_pkg.sv =====
// Shared types, constants and the microcode table for the integer to decimal text block.
package itdt_pkg;

   localparam int ValueWidth = 32;
   localparam int CharWidth  = 8;
   localparam int NumDigits  = 10;
   localparam int CntWidth   = 4;
   localparam int QuotWidth  = 29;
   localparam int RecipShift = 35;

   // floor(x / 10) == (x * DIV10_RECIP) >> 35 for every 32-bit x.
   localparam logic [ValueWidth-1:0] DIV10_RECIP = 32'hCCCC_CCCD;

   localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2D;

   // Datapath operations.
   localparam logic [2:0] OP_ACCEPT = 3'd0;
   localparam logic [2:0] OP_MUL    = 3'd1;
   localparam logic [2:0] OP_DIV    = 3'd2;
   localparam logic [2:0] OP_SIGN   = 3'd3;
   localparam logic [2:0] OP_DIGIT  = 3'd4;
   localparam logic [2:0] OP_NOP    = 3'd5;

   // Branch conditions.
   localparam logic [1:0] COND_NEXT = 2'd0;
   localparam logic [1:0] COND_JUMP = 2'd1;
   localparam logic [1:0] COND_QNZ  = 2'd2;
   localparam logic [1:0] COND_MORE = 2'd3;

   // Program steps.
   localparam logic [2:0] STEP_IDLE  = 3'd0;
   localparam logic [2:0] STEP_MUL   = 3'd1;
   localparam logic [2:0] STEP_DIV   = 3'd2;
   localparam logic [2:0] STEP_SIGN  = 3'd3;
   localparam logic [2:0] STEP_DIGIT = 3'd4;
   localparam logic [2:0] STEP_END   = 3'd5;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] cond;
      logic [2:0] target;
   } cw_type;

   typedef struct packed {
      logic [2:0] op;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic neg;
      logic q_nz;
      logic more;
   } stat_type;

   function automatic cw_type ucode(input logic [2:0] step);
      cw_type cw;
      case (step)
         STEP_IDLE:  cw = '{op: OP_ACCEPT, cond: COND_NEXT, target: STEP_IDLE};
         STEP_MUL:   cw = '{op: OP_MUL,    cond: COND_NEXT, target: STEP_IDLE};
         STEP_DIV:   cw = '{op: OP_DIV,    cond: COND_QNZ,  target: STEP_MUL};
         STEP_SIGN:  cw = '{op: OP_SIGN,   cond: COND_NEXT, target: STEP_IDLE};
         STEP_DIGIT: cw = '{op: OP_DIGIT,  cond: COND_MORE, target: STEP_DIGIT};
         STEP_END:   cw = '{op: OP_NOP,    cond: COND_JUMP, target: STEP_IDLE};
         default:    cw = '{op: OP_NOP,    cond: COND_JUMP, target: STEP_IDLE};
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/itdt_ifs.sv =====
// Valid/ready channel interfaces for the integer input and the character output.
interface itdt_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [itdt_pkg::ValueWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itdt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [itdt_pkg::CharWidth-1:0] text_char;
   logic                           last;

   modport source (output valid, output text_char, output last, input ready);
   modport sink   (input valid, input text_char, input last, output ready);
endinterface

// ===== rtl/itdt_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and branch logic.
module itdt_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  itdt_pkg::stat_type  stat,
   output itdt_pkg::ctrl_type  ctrl
);

   logic [2:0]       step_ff;
   logic [2:0]       step_in;
   itdt_pkg::cw_type cw;
   logic             hold;
   logic             take;

   assign cw      = itdt_pkg::ucode(step_ff);
   assign ctrl.op = cw.op;

   always_comb begin
      case (cw.op)
         itdt_pkg::OP_ACCEPT: hold = !stat.req_valid;
         itdt_pkg::OP_SIGN:   hold = stat.neg && !stat.out_free;
         itdt_pkg::OP_DIGIT:  hold = !stat.out_free;
         default:             hold = 1'b0;
      endcase
   end

   always_comb begin
      case (cw.cond)
         itdt_pkg::COND_NEXT: take = 1'b0;
         itdt_pkg::COND_JUMP: take = 1'b1;
         itdt_pkg::COND_QNZ:  take = stat.q_nz;
         itdt_pkg::COND_MORE: take = stat.more;
         default:             take = 1'b0;
      endcase
   end

   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else if (take) begin
         step_in = cw.target;
      end else begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= itdt_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/itdt_datapath.sv =====
// Datapath: magnitude register, divide-by-ten multiplier, digit stack and output register.
module itdt_datapath (
   input  logic               clock,
   input  logic               reset,
   input  itdt_pkg::ctrl_type ctrl,
   output itdt_pkg::stat_type stat,
   itdt_req_if.sink           req_ch,
   itdt_rsp_if.source         rsp_ch
);

   logic [itdt_pkg::ValueWidth-1:0] mag_ff, mag_in;
   logic                            neg_ff, neg_in;
   logic [itdt_pkg::QuotWidth-1:0]  q_ff, q_in;
   logic [itdt_pkg::CntWidth-1:0]   cnt_ff, cnt_in;
   logic [3:0]                      digits_ff [itdt_pkg::NumDigits];
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [itdt_pkg::CharWidth-1:0]  rsp_char_ff, rsp_char_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [2*itdt_pkg::ValueWidth-1:0] prod;
   logic [3:0]                        q10_lo;
   logic [3:0]                        rem;
   logic                              out_free;
   logic                              accept;
   logic                              push;
   logic                              pop;
   logic                              emit_sign;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = req_ch.ready && req_ch.valid;
   assign push      = (ctrl.op == itdt_pkg::OP_DIV);
   assign pop       = (ctrl.op == itdt_pkg::OP_DIGIT) && out_free;
   assign emit_sign = (ctrl.op == itdt_pkg::OP_SIGN) && neg_ff && out_free;

   assign req_ch.ready = (ctrl.op == itdt_pkg::OP_ACCEPT) && !reset;

   assign prod = 64'(mag_ff) * 64'(itdt_pkg::DIV10_RECIP);

   // Only the low nibble of q * 10 matters, since the remainder is below ten.
   assign q10_lo = {q_ff[0], 3'b000} + {q_ff[2:0], 1'b0};
   assign rem    = mag_ff[3:0] - q10_lo;

   assign stat.req_valid = req_ch.valid;
   assign stat.out_free  = out_free;
   assign stat.neg       = neg_ff;
   assign stat.q_nz      = (q_ff != '0);
   assign stat.more      = (cnt_ff != itdt_pkg::CntWidth'(1));

   always_comb begin
      mag_in = mag_ff;
      neg_in = neg_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         neg_in = req_ch.value[itdt_pkg::ValueWidth-1];
         mag_in = neg_in ? (32'd0 - $unsigned(req_ch.value)) : $unsigned(req_ch.value);
         cnt_in = '0;
      end else if (ctrl.op == itdt_pkg::OP_MUL) begin
         q_in = prod[2*itdt_pkg::ValueWidth-1:itdt_pkg::RecipShift];
      end else if (push) begin
         mag_in = itdt_pkg::ValueWidth'(q_ff);
         cnt_in = cnt_ff + itdt_pkg::CntWidth'(1);
      end else if (pop) begin
         cnt_in = cnt_ff - itdt_pkg::CntWidth'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = itdt_pkg::CHAR_MINUS;
         rsp_last_in  = 1'b0;
      end else if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = itdt_pkg::CHAR_ZERO + itdt_pkg::CharWidth'(digits_ff[0]);
         rsp_last_in  = (cnt_ff == itdt_pkg::CntWidth'(1));
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      q_ff        <= q_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digits arrive least significant first; the stack hands them back most significant first.
   always_ff @(posedge clock) begin
      if (push) begin
         digits_ff[0] <= rem;
         for (int i = 1; i < itdt_pkg::NumDigits; i++) begin
            digits_ff[i] <= digits_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < itdt_pkg::NumDigits - 1; i++) begin
            digits_ff[i] <= digits_ff[i+1];
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.text_char = rsp_char_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule

// ===== rtl/integer_to_decimal_text.sv =====
// Signed 32-bit integer to ASCII decimal text: one input beat in, one character per output beat.
//
// The req_ch channel takes one signed 32-bit value per beat. The rsp_ch channel returns its
// decimal text, one ASCII character per beat: a minus sign for negative values, then the
// digits from most to least significant, with last set on the final character.
// A small microprogram runs each value: one accept step, then a multiply and a divide step
// per digit (the divide by ten is a reciprocal multiply, registered between the two steps),
// then a sign step, one step per digit sent and one closing step. The first character
// appears on rsp_ch from an output register: the minus sign for a negative value, else the
// most significant digit.
// A stalled rsp_ch holds the current character and freezes the program on the step that
// wants to send; req_ch.ready is high only while the program waits on its accept step.
// Synchronous reset returns the program to that step, holds req_ch.ready low while it is
// asserted and empties the output register.
module integer_to_decimal_text (
   input logic        clock,
   input logic        reset,
   itdt_req_if.sink   req_ch,
   itdt_rsp_if.source rsp_ch
);

   itdt_pkg::ctrl_type ctrl;
   itdt_pkg::stat_type stat;

   itdt_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   itdt_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .stat   (stat),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // An accepted beat always starts the divide loop.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (ctrl.op == itdt_pkg::OP_MUL))
      else $error("accepted value did not start the divide loop");

   // For a value that is not negative, the sign step sends nothing and hands straight over to the digit output.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == itdt_pkg::OP_SIGN && !stat.neg) |=> (ctrl.op == itdt_pkg::OP_DIGIT))
      else $error("sign step did not hand over to digit output");

   // Sending the final digit ends the run and marks it last.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == itdt_pkg::OP_DIGIT && stat.out_free && !stat.more)
      |=> (ctrl.op == itdt_pkg::OP_NOP && rsp_ch.valid && rsp_ch.last))
      else $error("final digit not flagged last or run not closed");

   // No input is taken while digits are being sent.
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == itdt_pkg::OP_DIGIT) |-> !req_ch.ready)
      else $error("input ready during digit output");

endmodule

// ===== tb/integer_to_decimal_text_tb.sv =====
// Self-checking testbench for the integer to decimal text block, with random stimulus and idling.
module integer_to_decimal_text_tb;

   localparam int CycleLimit  = 400000;
   localparam int LongHold    = 300;
   localparam int DrainCycles = 40;
   localparam int ReportMax   = 10;

   typedef struct packed {
      logic [itdt_pkg::CharWidth-1:0] text_char;
      logic                           last;
   } char_beat_type;

   logic clock;
   logic reset;

   itdt_req_if req_ch ();
   itdt_rsp_if rsp_ch ();

   integer_to_decimal_text dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic signed [itdt_pkg::ValueWidth-1:0] pending_values[$];
   char_beat_type                          awaited_chars[$];

   int   mismatch_count = 0;
   int   cycle_count    = 0;
   int   send_gap       = 0;
   int   recv_gap       = 0;
   int   hold_left      = 0;
   logic offering;
   logic taking;
   logic calm           = 1'b0;
   logic rsp_hold_armed = 1'b0;
   logic rsp_hold_done  = 1'b0;
   char_beat_type want;

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Expected characters for one value: sign, then digits most significant first.
   function automatic void spell_decimal(input logic signed [itdt_pkg::ValueWidth-1:0] value);
      logic [itdt_pkg::ValueWidth-1:0] mag;
      logic [itdt_pkg::CharWidth-1:0]  digit_chars[itdt_pkg::NumDigits];
      int                              n;
      mag = value[itdt_pkg::ValueWidth-1] ? 32'd0 - unsigned'(value) : unsigned'(value);
      n = 0;
      do begin
         digit_chars[n] = itdt_pkg::CHAR_ZERO + itdt_pkg::CharWidth'(mag % 10);
         n++;
         mag = mag / 10;
      end while (mag != 0);
      if (value[itdt_pkg::ValueWidth-1]) begin
         awaited_chars.push_back('{text_char: itdt_pkg::CHAR_MINUS, last: 1'b0});
      end
      for (int i = n - 1; i >= 0; i--) begin
         awaited_chars.push_back('{text_char: digit_chars[i], last: (i == 0)});
      end
   endfunction

   // Mostly values of a random digit count, some near powers of ten, some raw patterns.
   function automatic logic signed [itdt_pkg::ValueWidth-1:0] random_value();
      int     kind;
      int     d;
      longint lo;
      longint hi;
      longint mag;
      kind = $urandom_range(0, 19);
      if (kind < 5) return $urandom;
      if (kind == 5) return 32'h8000_0000;
      if (kind < 9) begin
         mag = 1;
         repeat ($urandom_range(0, 9)) mag = mag * 10;
         mag = mag + $urandom_range(0, 2) - 1;
      end else begin
         d  = $urandom_range(1, 10);
         lo = 1;
         repeat (d - 1) lo = lo * 10;
         hi = lo * 10 - 1;
         if (d == 1) lo = 0;
         if (hi > 64'sd2147483647) hi = 64'sd2147483647;
         mag = lo + (longint'($urandom) % (hi - lo + 1));
      end
      if ($urandom_range(0, 1) == 1) mag = -mag;
      return itdt_pkg::ValueWidth'(mag);
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Sender: a value held on the channel stays until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            spell_decimal(req_ch.value);
            void'(pending_values.pop_front());
            offering = 1'b0;
         end else begin
            offering = req_ch.valid;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 11);
            end else if (pending_values.size() > 0) begin
               offering = 1'b1;
            end
         end
         req_ch.valid <= offering;
         if (offering) req_ch.value <= pending_values[0];
      end
   end

   // Receiver: checks each character beat and stalls in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportMax)
                  $display("unexpected beat: char %0d last %0b", rsp_ch.text_char, rsp_ch.last);
            end else begin
               want = awaited_chars.pop_front();
               if (rsp_ch.text_char !== want.text_char || rsp_ch.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= ReportMax)
                     $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                              want.text_char, want.last, rsp_ch.text_char, rsp_ch.last);
               end
            end
         end
         if (rsp_hold_armed && !rsp_hold_done) begin
            rsp_hold_done = 1'b1;
            hold_left = LongHold;
         end
         taking = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
         end else if (recv_gap > 0) begin
            recv_gap--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 11);
         end else begin
            taking = 1'b1;
         end
         rsp_ch.ready <= taking;
      end
   end

   task automatic wait_all_done();
      while (pending_values.size() != 0 || awaited_chars.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Extremes, digit-count boundaries and both signs.
      pending_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd9, -32'sd10,
                         32'sd99, 32'sd100, -32'sd100, 32'sd7, -32'sd123,
                         32'sd2147483647, 32'h8000_0000, -32'sd2147483647,
                         32'sd1000000000, 32'sd999999999, -32'sd1000000000,
                         -32'sd999999999, 32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA};
      wait_all_done();

      // The receiver stops for a long stretch while values keep coming.
      repeat (120) pending_values.push_back(random_value());
      rsp_hold_armed <= 1'b1;
      wait_all_done();

      repeat (100) pending_values.push_back(random_value());
      while (pending_values.size() != 0) @(posedge clock);
      calm <= 1'b1;
      repeat (40) pending_values.push_back(random_value());
      wait_all_done();
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && awaited_chars.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
